### src/three_level_page_run_allocator_top_assert.svh
// Assertion macros for the page run allocator.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef THREE_LEVEL_PAGE_RUN_ALLOCATOR_TOP_ASSERT_SVH
`define THREE_LEVEL_PAGE_RUN_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TLPA_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("tlpa assertion failed");
`define TLPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("tlpa implication failed");
`else
`define TLPA_ASSERT(lbl, clk, rstn, prop)
`define TLPA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

### src/tlpa_pkg.sv
// Shared types, codes and defaults for the page run allocator.
// No dependencies.
`timescale 1ns / 1ps
package tlpa_pkg;
	// parameter defaults
	localparam int RUNS_PER_LEVEL_DEF  = 256;
	localparam int LEVEL_SHIFT_DEF     = 9;
	localparam int BASE_PAGE_SHIFT_DEF = 12;
	localparam int ADDRESS_BITS_DEF    = 48;

	// field widths
	localparam int COUNT_W     = 32;
	localparam int START_W     = 48;
	localparam int LEVEL_W     = 2;
	localparam int STATUS_W    = 2;
	localparam int LEVELS      = 3;
	localparam int IN_TDATA_W  = 80;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 56;

	// commands and levels
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;
	localparam logic [LEVEL_W-1:0] LVL_BASE = 2'd0;
	localparam logic [LEVEL_W-1:0] TOP_LVL  = 2'd2;
	localparam logic [LEVEL_W-1:0] LVL_NONE = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_OOM  = 2'd1,
		ST_FULL = 2'd2,
		ST_ZERO = 2'd3
	} tlpa_st_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     do_free;
		logic     rd_scan;
		logic     hit_split;
		logic     hit_exact;
		logic     mv_last;
		logic     next_idx;
		logic     go_up;
		logic     left_app;
		logic     set_st;
		tlpa_st_t st;
		logic     out_load;
	} tlpa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic zero;
		logic is_free;
		logic bad_lvl;
		logic used_zero;
		logic hit;
		logic exact;
		logic scan_last;
		logic top;
		logic at_org;
		logic out_free;
	} tlpa_sts_t;
endpackage

### src/tlpa_datapath.sv
// Datapath: run tables (one memory), fill counts, scan index and result register.
// Depends on tlpa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "three_level_page_run_allocator_top_assert.svh"
module tlpa_datapath #(
	parameter int RUNS_PER_LEVEL  = tlpa_pkg::RUNS_PER_LEVEL_DEF,
	parameter int LEVEL_SHIFT     = tlpa_pkg::LEVEL_SHIFT_DEF,
	parameter int BASE_PAGE_SHIFT = tlpa_pkg::BASE_PAGE_SHIFT_DEF,
	parameter int ADDRESS_BITS    = tlpa_pkg::ADDRESS_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tlpa_pkg::tlpa_cmd_t            cmd,
	output tlpa_pkg::tlpa_sts_t            sts,
	input  logic                           in_command,
	input  logic [tlpa_pkg::LEVEL_W-1:0]   in_level,
	input  logic [tlpa_pkg::COUNT_W-1:0]   in_page_count,
	input  logic [tlpa_pkg::START_W-1:0]   in_page_start,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [tlpa_pkg::START_W-1:0]   out_address,
	output logic [tlpa_pkg::STATUS_W-1:0]  out_status
);
	import tlpa_pkg::*;

	localparam int XW     = $clog2(RUNS_PER_LEVEL);
	localparam int UW     = $clog2(RUNS_PER_LEVEL + 1);
	localparam int DEPTH  = LEVELS * RUNS_PER_LEVEL;
	localparam int IW     = $clog2(DEPTH);
	localparam int WW     = START_W + COUNT_W;
	localparam int AW_EFF = (ADDRESS_BITS < START_W) ? ADDRESS_BITS : START_W;
	localparam logic [START_W-1:0] AMASK = START_W'((64'd1 << AW_EFF) - 64'd1);

	// run table: {start, count} per entry
	logic [WW-1:0] mem [DEPTH];
	logic [WW-1:0] rdata_q;
	logic          mem_we, mem_re;
	logic [IW-1:0] mem_wa, mem_ra;
	logic [WW-1:0] mem_wd;

	logic                cmd_q;
	logic [LEVEL_W-1:0]  lvl_q, org_q;
	logic [COUNT_W-1:0]  cnt_in_q;
	logic [START_W-1:0]  start_in_q;
	logic [COUNT_W-1:0]  nlev_q [LEVELS];
	logic [UW-1:0]       used_q [LEVELS];
	logic [XW-1:0]       idx_q;
	logic [START_W-1:0]  addr_q;
	tlpa_st_t            st_q;
	logic                m_valid_q;
	logic [START_W-1:0]  m_addr_q;
	tlpa_st_t            m_st_q;

	logic [LEVEL_W-1:0]  lvl_ix, lo_ix;
	logic [UW-1:0]       used_cur, used_lo, used_m1;
	logic [COUNT_W-1:0]  n_cur, n_lo;
	logic [START_W-1:0]  rd_start;
	logic [COUNT_W-1:0]  rd_count;
	logic [COUNT_W:0]    up_sum, left_w;
	logic                free_ok, left_ok;

	function automatic logic [IW-1:0] lvl_base(input logic [LEVEL_W-1:0] l);
		logic [IW-1:0] b;
		case (l)
			2'd1:    b = IW'(RUNS_PER_LEVEL);
			2'd2:    b = IW'(2 * RUNS_PER_LEVEL);
			default: b = '0;
		endcase
		return b;
	endfunction

	// byte offset of n pages at level l, wrapped to the address width
	function automatic logic [START_W-1:0] page_off(input logic [LEVEL_W-1:0] l,
			input logic [COUNT_W-1:0] n);
		logic [63:0] s;
		case (l)
			2'd0:    s = 64'(n) << BASE_PAGE_SHIFT;
			2'd1:    s = 64'(n) << (BASE_PAGE_SHIFT + LEVEL_SHIFT);
			default: s = 64'(n) << (BASE_PAGE_SHIFT + 2 * LEVEL_SHIFT);
		endcase
		return s[START_W-1:0] & AMASK;
	endfunction

	function automatic logic [START_W-1:0] in_start_masked(input logic [START_W-1:0] a);
		return a & AMASK;
	endfunction

	// current level views
	assign lvl_ix   = (lvl_q == LVL_NONE) ? TOP_LVL : lvl_q;
	assign lo_ix    = lvl_ix - LEVEL_W'(1);
	assign used_cur = used_q[lvl_ix];
	assign used_lo  = used_q[lo_ix];
	assign used_m1  = used_cur - UW'(1);
	assign n_cur    = nlev_q[lvl_ix];
	assign n_lo     = nlev_q[lo_ix];
	assign rd_start = rdata_q[COUNT_W +: START_W];
	assign rd_count = rdata_q[COUNT_W-1:0];
	assign up_sum   = {1'b0, n_cur} + (COUNT_W+1)'((1 << LEVEL_SHIFT) - 1);
	assign left_w   = ((COUNT_W+1)'(n_cur) << LEVEL_SHIFT) - {1'b0, n_lo};
	assign free_ok  = used_cur < UW'(RUNS_PER_LEVEL);
	assign left_ok  = (used_lo < UW'(RUNS_PER_LEVEL)) && (left_w != '0);

	// status to controller
	always_comb begin
		sts.zero      = cnt_in_q == '0;
		sts.is_free   = cmd_q == CMD_FREE;
		sts.bad_lvl   = lvl_q == LVL_NONE;
		sts.used_zero = used_cur == '0;
		sts.hit       = rd_count >= n_cur;
		sts.exact     = rd_count == n_cur;
		sts.scan_last = (UW'(idx_q) + UW'(1)) >= used_cur;
		sts.top       = lvl_q == TOP_LVL;
		sts.at_org    = lvl_q == org_q;
		sts.out_free  = !m_valid_q || out_ready;
	end

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = lvl_base(lvl_ix) + IW'(idx_q);
		mem_ra = lvl_base(lvl_ix) + IW'(idx_q);
		mem_wd = rdata_q;
		if (cmd.do_free) begin
			mem_we = free_ok;
			mem_wa = lvl_base(lvl_ix) + IW'(used_cur[XW-1:0]);
			mem_wd = {in_start_masked(start_in_q), cnt_in_q};
		end
		if (cmd.rd_scan) begin
			mem_re = 1'b1;
		end
		if (cmd.hit_exact) begin
			mem_re = 1'b1;
			mem_ra = lvl_base(lvl_ix) + IW'(used_m1[XW-1:0]);
		end
		if (cmd.hit_split) begin
			mem_we = 1'b1;
			mem_wd = {(rd_start + page_off(lvl_ix, n_cur)) & AMASK, rd_count - n_cur};
		end
		if (cmd.mv_last) begin
			mem_we = 1'b1;
		end
		if (cmd.left_app) begin
			mem_we = left_ok;
			mem_wa = lvl_base(lo_ix) + IW'(used_lo[XW-1:0]);
			mem_wd = {(addr_q + page_off(lo_ix, n_lo)) & AMASK, left_w[COUNT_W-1:0]};
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rdata_q <= mem[mem_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++)
				used_q[i] <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.do_free && free_ok)
				used_q[lvl_ix] <= used_cur + UW'(1);
			if (cmd.mv_last)
				used_q[lvl_ix] <= used_m1;
			if (cmd.left_app && left_ok)
				used_q[lo_ix] <= used_lo + UW'(1);
			if (cmd.out_load)
				m_valid_q <= 1'b1;
			else if (out_ready)
				m_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q      <= in_command;
			lvl_q      <= in_level;
			org_q      <= in_level;
			cnt_in_q   <= in_page_count;
			start_in_q <= in_page_start;
			idx_q      <= '0;
			addr_q     <= '0;
			if (in_level != LVL_NONE)
				nlev_q[in_level] <= in_page_count;
		end
		if (cmd.do_free)
			st_q <= free_ok ? ST_OK : ST_FULL;
		if (cmd.set_st)
			st_q <= cmd.st;
		if (cmd.next_idx)
			idx_q <= idx_q + XW'(1);
		if (cmd.hit_split || cmd.hit_exact)
			addr_q <= rd_start;
		if (cmd.go_up) begin
			nlev_q[lvl_ix + LEVEL_W'(1)] <= COUNT_W'(up_sum >> LEVEL_SHIFT);
			lvl_q <= lvl_q + LEVEL_W'(1);
			idx_q <= '0;
		end
		if (cmd.left_app)
			lvl_q <= lvl_q - LEVEL_W'(1);
		if (cmd.out_load) begin
			m_addr_q <= addr_q;
			m_st_q   <= st_q;
		end
	end

	assign out_valid   = m_valid_q;
	assign out_address = m_addr_q;
	assign out_status  = m_st_q;

	`TLPA_ASSERT(a_used_bound, clk, arst_n, used_q[0] <= UW'(RUNS_PER_LEVEL) && used_q[1] <= UW'(RUNS_PER_LEVEL) && used_q[2] <= UW'(RUNS_PER_LEVEL))
	`TLPA_ASSERT(a_one_op, clk, arst_n, $onehot0({cmd.do_free, cmd.rd_scan, cmd.hit_split, cmd.hit_exact, cmd.mv_last, cmd.left_app}))
	`TLPA_ASSERT_IMP(a_out_safe, clk, arst_n, cmd.out_load, !m_valid_q || out_ready)
	`TLPA_ASSERT_IMP(a_scan_lvl, clk, arst_n, cmd.rd_scan, lvl_q != LVL_NONE && used_cur != '0)
	`TLPA_ASSERT_IMP(a_move_follows, clk, arst_n, cmd.hit_exact, ##1 cmd.mv_last)
endmodule

### src/tlpa_ctrl.sv
// Controller: sequences dispatch, table scan, level climb and leftover appends.
// Depends on tlpa_pkg.
`timescale 1ns / 1ps
module tlpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tlpa_pkg::tlpa_sts_t sts,
	output tlpa_pkg::tlpa_cmd_t cmd
);
	import tlpa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_CHK, S_SCAN, S_CMP, S_MOVE, S_MISS, S_LEFT, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   ready_q;

	assign in_ready = ready_q;

	// command decode and next state
	always_comb begin
		cmd     = '0;
		cmd.st  = ST_OK;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && ready_q) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.zero) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_ZERO;
					state_d    = S_DONE;
				end else if (sts.bad_lvl) begin
					cmd.set_st = 1'b1;
					cmd.st     = sts.is_free ? ST_FULL : ST_OOM;
					state_d    = S_DONE;
				end else if (sts.is_free) begin
					cmd.do_free = 1'b1;
					state_d     = S_DONE;
				end else begin
					state_d = sts.used_zero ? S_MISS : S_SCAN;
				end
			end
			S_CHK: state_d = sts.used_zero ? S_MISS : S_SCAN;
			S_SCAN: begin
				cmd.rd_scan = 1'b1;
				state_d     = S_CMP;
			end
			S_CMP: begin
				if (sts.hit && !sts.exact) begin
					cmd.hit_split = 1'b1;
					state_d       = S_LEFT;
				end else if (sts.hit) begin
					cmd.hit_exact = 1'b1;
					state_d       = S_MOVE;
				end else if (sts.scan_last) begin
					state_d = S_MISS;
				end else begin
					cmd.next_idx = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_MOVE: begin
				cmd.mv_last = 1'b1;
				state_d     = S_LEFT;
			end
			S_MISS: begin
				if (sts.top) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_OOM;
					state_d    = S_DONE;
				end else begin
					cmd.go_up = 1'b1;
					state_d   = S_CHK;
				end
			end
			S_LEFT: begin
				if (sts.at_org) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_OK;
					state_d    = S_DONE;
				end else begin
					cmd.left_app = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and ready register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				ready_q <= 1'b0;
			else if (cmd.out_load)
				ready_q <= 1'b1;
		end
	end
endmodule

### src/three_level_page_run_allocator_top.sv
// Channel    | Dir | tdata (low bit up)                     | tuser (low bit up)
// s_axis     | in  | page_count[31:0], page_start[79:32]    | command[0], level[2:1]
// m_axis     | out | address[47:0], status[49:48], pad     | -
// A free appends its run to the table at its level; an allocate scans table entries,
// climbs a level on a miss, moves the last entry on an exact fit and appends leftovers,
// one table read at a time through the single memory read port.
// Reset clears fill counts, output valid and controller state; table contents are undefined until written.
// A finished result waits in the output register; the next item is accepted
// once the result is loaded there, whether or not it has been taken.
// Depends on tlpa_pkg, tlpa_ctrl and tlpa_datapath.
`timescale 1ns / 1ps
module three_level_page_run_allocator_top #(
	parameter int RUNS_PER_LEVEL  = tlpa_pkg::RUNS_PER_LEVEL_DEF,
	parameter int LEVEL_SHIFT     = tlpa_pkg::LEVEL_SHIFT_DEF,
	parameter int BASE_PAGE_SHIFT = tlpa_pkg::BASE_PAGE_SHIFT_DEF,
	parameter int ADDRESS_BITS    = tlpa_pkg::ADDRESS_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [tlpa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // page_count, page_start
	input  logic [tlpa_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // command, level
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [tlpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // address, status, zero pad
);
	import tlpa_pkg::*;

	tlpa_cmd_t             cmd;
	tlpa_sts_t             sts;
	logic [START_W-1:0]    address;
	logic [STATUS_W-1:0]   status;

	tlpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlpa_datapath #(
		.RUNS_PER_LEVEL  (RUNS_PER_LEVEL),
		.LEVEL_SHIFT     (LEVEL_SHIFT),
		.BASE_PAGE_SHIFT (BASE_PAGE_SHIFT),
		.ADDRESS_BITS    (ADDRESS_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_command    (s_axis_tuser[0]),
		.in_level      (s_axis_tuser[2:1]),
		.in_page_count (s_axis_tdata[COUNT_W-1:0]),
		.in_page_start (s_axis_tdata[COUNT_W +: START_W]),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_address   (address),
		.out_status    (status)
	);

	// pack result
	assign m_axis_tdata = {{(OUT_TDATA_W - START_W - STATUS_W){1'b0}}, status, address};
endmodule
